// ===== sv/rqt_pkg.sv =====
package rqt_pkg;

	localparam int FRAC_BITS = 30;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_BITS = 31;
	localparam int PREP_IDX = SQRT_STAGES + 1;
	localparam int NPIPE = PREP_IDX + DIV_BITS + 1;
	localparam int LANES = 3;

	typedef enum logic [1:0] {
		SLOT_W = 2'd0,
		SLOT_X = 2'd1,
		SLOT_Y = 2'd2,
		SLOT_Z = 2'd3
	} slot_t;

	typedef struct packed {
		logic signed [31:0] r00;
		logic signed [31:0] r01;
		logic signed [31:0] r02;
		logic signed [31:0] r10;
		logic signed [31:0] r11;
		logic signed [31:0] r12;
		logic signed [31:0] r20;
		logic signed [31:0] r21;
		logic signed [31:0] r22;
	} mat_word_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic degenerate;
	} quat_word_t;

	typedef struct packed {
		slot_t prim;
		logic degen;
		logic [63:0] rad;
		logic [34:0] srem;
		logic [31:0] root;
		logic [LANES-1:0] neg;
		logic [LANES-1:0][32:0] mag;
		logic [LANES-1:0][DIV_BITS-1:0] nlow;
		logic [LANES-1:0][33:0] drem;
		logic [LANES-1:0][DIV_BITS-1:0] quo;
		logic [LANES-1:0] ovf;
	} stage_t;

endpackage

// ===== sv/rqt_mat_if.sv =====
interface rqt_mat_if;
	logic valid;
	logic ready;
	rqt_pkg::mat_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rqt_quat_if.sv =====
interface rqt_quat_if;
	logic valid;
	logic ready;
	rqt_pkg::quat_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rotation_matrix_to_quaternion.sv =====
// path: decode, square root, divider setup, division, output format, each registered
// throughput: one word per cycle; 32 square root stages (one root bit each)
// and 31 divider stages (one quotient bit per lane each) set the depth
// a stall at the output holds the whole pipeline in place
// reset: arst_n clears all valid bits asynchronously, data is not reset
module rotation_matrix_to_quaternion (
	input logic clk,
	input logic arst_n,
	rqt_mat_if.sink mat,
	rqt_quat_if.source quat
);
	import rqt_pkg::*;

	stage_t pipe_s [NPIPE];
	stage_t nx [NPIPE];
	logic [NPIPE:0] vld_s;
	quat_word_t out_s;
	quat_word_t out_nx;
	logic en;

	assign en = !vld_s[NPIPE] || quat.ready;
	assign mat.ready = en;
	assign quat.valid = vld_s[NPIPE];
	assign quat.data = out_s;

	// decode
	always_comb begin
		logic signed [31:0] mm [3][3];
		logic signed [34:0] trace;
		logic signed [34:0] rad35;
		logic signed [32:0] d [LANES];
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
		mm[0][0] = mat.data.r00; mm[0][1] = mat.data.r01; mm[0][2] = mat.data.r02;
		mm[1][0] = mat.data.r10; mm[1][1] = mat.data.r11; mm[1][2] = mat.data.r12;
		mm[2][0] = mat.data.r20; mm[2][1] = mat.data.r21; mm[2][2] = mat.data.r22;
		nx[0] = '0;
		trace = 35'(mm[0][0]) + 35'(mm[1][1]) + 35'(mm[2][2]);
		i = 2'd0; j = 2'd1; k = 2'd2;
		if (trace > 0) begin
			rad35 = trace + (35'sd1 <<< FRAC_BITS);
			nx[0].prim = SLOT_W;
			d[0] = 33'(mm[2][1]) - 33'(mm[1][2]);
			d[1] = 33'(mm[0][2]) - 33'(mm[2][0]);
			d[2] = 33'(mm[1][0]) - 33'(mm[0][1]);
		end else begin
			if (mm[0][0] < mm[1][1]) i = (mm[1][1] < mm[2][2]) ? 2'd2 : 2'd1;
			else i = (mm[0][0] < mm[2][2]) ? 2'd2 : 2'd0;
			j = (i == 2'd2) ? 2'd0 : i + 2'd1;
			k = (j == 2'd2) ? 2'd0 : j + 2'd1;
			rad35 = 35'(mm[i][i]) - 35'(mm[j][j]) - 35'(mm[k][k])
				+ (35'sd1 <<< FRAC_BITS);
			nx[0].prim = slot_t'(i + 2'd1);
			d[0] = 33'(mm[k][j]) - 33'(mm[j][k]);
			d[1] = 33'(mm[j][i]) + 33'(mm[i][j]);
			d[2] = 33'(mm[k][i]) + 33'(mm[i][k]);
		end
		nx[0].degen = (rad35 <= 0);
		nx[0].rad = nx[0].degen ? 64'd0 : (64'(rad35[32:0]) << FRAC_BITS);
		for (int l = 0; l < LANES; l++) begin
			nx[0].neg[l] = d[l][32];
			nx[0].mag[l] = d[l][32] ? 33'(-d[l]) : 33'(d[l]);
		end
	end

	// square root, one root bit per stage
	for (genvar g = 1; g <= SQRT_STAGES; g++) begin : g_sqrt
		localparam int N = SQRT_STAGES - g;
		always_comb begin
			logic [34:0] sh;
			logic [34:0] t;
			nx[g] = pipe_s[g-1];
			sh = {pipe_s[g-1].srem[32:0], pipe_s[g-1].rad[2*N+1 -: 2]};
			t = {1'b0, pipe_s[g-1].root, 2'b01};
			if (sh >= t) begin
				nx[g].srem = sh - t;
				nx[g].root = {pipe_s[g-1].root[30:0], 1'b1};
			end else begin
				nx[g].srem = sh;
				nx[g].root = {pipe_s[g-1].root[30:0], 1'b0};
			end
		end
	end

	// divider setup, overflow check
	always_comb begin
		logic [63:0] num;
		logic [64:0] lim;
		nx[PREP_IDX] = pipe_s[PREP_IDX-1];
		lim = 65'({pipe_s[PREP_IDX-1].root, 1'b0}) << DIV_BITS;
		for (int l = 0; l < LANES; l++) begin
			num = (64'(pipe_s[PREP_IDX-1].mag[l]) << FRAC_BITS)
				+ 64'(pipe_s[PREP_IDX-1].root);
			nx[PREP_IDX].ovf[l] = ({1'b0, num} >= lim);
			nx[PREP_IDX].drem[l] = 34'(num[63:DIV_BITS]);
			nx[PREP_IDX].nlow[l] = num[DIV_BITS-1:0];
			nx[PREP_IDX].quo[l] = '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar g = PREP_IDX + 1; g < NPIPE; g++) begin : g_div
		localparam int N = NPIPE - 1 - g;
		always_comb begin
			logic [33:0] sh;
			logic [33:0] den;
			nx[g] = pipe_s[g-1];
			den = {1'b0, pipe_s[g-1].root, 1'b0};
			for (int l = 0; l < LANES; l++) begin
				sh = {pipe_s[g-1].drem[l][32:0], pipe_s[g-1].nlow[l][N]};
				if (sh >= den) begin
					nx[g].drem[l] = sh - den;
					nx[g].quo[l][N] = 1'b1;
				end else begin
					nx[g].drem[l] = sh;
				end
			end
		end
	end

	// output format
	always_comb begin
		stage_t p;
		logic [32:0] pv;
		logic [31:0] lv [LANES];
		p = pipe_s[NPIPE-1];
		pv = ({1'b0, p.root} + 33'd1) >> 1;
		for (int l = 0; l < LANES; l++) begin
			if (p.ovf[l]) lv[l] = p.neg[l] ? 32'h8000_0000 : 32'h7fff_ffff;
			else if (p.neg[l]) lv[l] = 32'(-{1'b0, p.quo[l]});
			else lv[l] = {1'b0, p.quo[l]};
		end
		out_nx = '0;
		out_nx.degenerate = p.degen;
		if (!p.degen) begin
			unique case (p.prim)
				SLOT_W: begin
					out_nx.quat_w = pv[31:0];
					out_nx.quat_x = lv[0]; out_nx.quat_y = lv[1]; out_nx.quat_z = lv[2];
				end
				SLOT_X: begin
					out_nx.quat_x = pv[31:0];
					out_nx.quat_w = lv[0]; out_nx.quat_y = lv[1]; out_nx.quat_z = lv[2];
				end
				SLOT_Y: begin
					out_nx.quat_y = pv[31:0];
					out_nx.quat_w = lv[0]; out_nx.quat_z = lv[1]; out_nx.quat_x = lv[2];
				end
				SLOT_Z: begin
					out_nx.quat_z = pv[31:0];
					out_nx.quat_w = lv[0]; out_nx.quat_x = lv[1]; out_nx.quat_y = lv[2];
				end
				default: out_nx = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NPIPE-1:0], mat.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NPIPE; s++) pipe_s[s] <= nx[s];
			out_s <= out_nx;
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.data.degenerate |-> quat.data.quat_w == 0
		&& quat.data.quat_x == 0 && quat.data.quat_y == 0 && quat.data.quat_z == 0)
		else $error("degenerate word with nonzero parts");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> vld_s[0])
		else $error("accepted word lost at pipeline entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s == $past(vld_s))
		else $error("pipeline moved during stall");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		mat.ready == (!quat.valid || quat.ready))
		else $error("input ready out of step with output");

endmodule
